// ===== hdl/japanese_encoding_converter_top_defines.svh =====
// assertion macros for the japanese encoding converter
`ifndef JAPANESE_ENCODING_CONVERTER_TOP_DEFINES_SVH
`define JAPANESE_ENCODING_CONVERTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define JEC_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define JEC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define JEC_ASSERT(name, clk, rst_n, prop, msg)
`define JEC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hdl/jec_pkg.sv =====
// shared types, constants and byte classes of the japanese encoding converter
package jec_pkg;

    localparam logic [7:0] ESC_BYTE    = 8'h1B;
    localparam logic [7:0] DOLLAR_BYTE = 8'h24;
    localparam logic [7:0] PAREN_BYTE  = 8'h28;
    localparam logic [7:0] LF_BYTE     = 8'h0A;
    localparam int         BURST_DEPTH = 7;

    typedef enum logic [2:0] {
        PK_NONE = 3'd0,
        PK_ESC  = 3'd1,
        PK_DOL  = 3'd2,
        PK_PAR  = 3'd3,
        PK_JIS  = 3'd4,
        PK_SJ   = 3'd5,
        PK_EU   = 3'd6
    } t_pend;

    typedef enum logic [1:0] {
        OC_JIS  = 2'd0,
        OC_SJIS = 2'd1,
        OC_EUC  = 2'd2
    } t_ocode;

    typedef enum logic [1:0] {
        CFG_OUTPUT_CODE     = 2'd0,
        CFG_KANJI_IN_FINAL  = 2'd1,
        CFG_KANJI_OUT_FINAL = 2'd2,
        CFG_PREFER_EUC      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0] output_code;
        logic [7:0] kanji_in_final;
        logic [7:0] kanji_out_final;
    } t_cfg;

    typedef struct packed {
        t_pend      pend;
        logic [7:0] held;
        logic [1:0] km;
        logic       pref;
    } t_state;

    typedef struct packed {
        logic [BURST_DEPTH-1:0][7:0] data;
        logic [2:0]                  cnt;
    } t_burst;

    typedef struct packed {
        logic eu2;
        logic eu1;
        logic sj2;
        logic sj1;
        logic jis;
        logic jout;
        logic jin;
    } t_class;

    function automatic t_class byte_class(input logic [7:0] c);
        t_class r;
        r = '0;
        if (c >= 8'h21 && c <= 8'h3F) begin
            r.jis = 1'b1;
        end else if (c == 8'h40) begin
            r.sj2 = 1'b1;
            r.jis = 1'b1;
            r.jin = 1'b1;
        end else if (c == 8'h42) begin
            r.sj2  = 1'b1;
            r.jis  = 1'b1;
            r.jout = 1'b1;
            r.jin  = 1'b1;
        end else if (c == 8'h48 || c == 8'h4A) begin
            r.sj2  = 1'b1;
            r.jis  = 1'b1;
            r.jout = 1'b1;
        end else if (c >= 8'h41 && c <= 8'h7E) begin
            r.sj2 = 1'b1;
            r.jis = 1'b1;
        end else if (c == 8'h80 || c == 8'hA0) begin
            r.sj2 = 1'b1;
        end else if (c >= 8'h81 && c <= 8'h9F) begin
            r.sj2 = 1'b1;
            r.sj1 = 1'b1;
        end else if (c >= 8'hA1 && c <= 8'hDF) begin
            r.eu2 = 1'b1;
            r.eu1 = 1'b1;
            r.sj2 = 1'b1;
        end else if (c >= 8'hE0 && c <= 8'hFC) begin
            r.eu2 = 1'b1;
            r.eu1 = 1'b1;
            r.sj2 = 1'b1;
            r.sj1 = 1'b1;
        end else if (c == 8'hFD || c == 8'hFE) begin
            r.eu2 = 1'b1;
            r.eu1 = 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== hdl/jec_ifs.sv =====
// handshake channel interfaces: input bytes, output bytes, configuration writes
interface jec_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] in_byte;
    modport source (output valid, output op, output in_byte, input ready);
    modport sink (input valid, input op, input in_byte, output ready);
endinterface

interface jec_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;
    modport source (output valid, output out_byte, output last, input ready);
    modport sink (input valid, input out_byte, input last, output ready);
endinterface

interface jec_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] idx;
    logic [7:0] data;
    modport source (output valid, output idx, output data, input ready);
    modport sink (input valid, input idx, input data, output ready);
endinterface

// ===== hdl/japanese_encoding_converter_top.sv =====
// top level of the japanese encoding converter
`include "japanese_encoding_converter_top_defines.svh"

// Converts a Japanese text byte stream (JIS escapes, Shift-JIS or EUC pairs) into
// the encoding selected by output_code. An input transaction is taken into an input
// register, translated in one pass into a burst of zero to seven result bytes, and
// the burst is loaded into the output register while the decode state updates. The
// output register sends one byte per cycle while the receiver is ready, and a burst
// holds the input side until its last byte is taken; inputs that yield zero or one
// byte flow at one per cycle while the receiver is ready. The first result byte is
// offered once its input has passed the input register and the output register.
// Configuration writes are always accepted and take effect on the next cycle.
module japanese_encoding_converter_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jec_cfg_if.sink   i_cfg,
    jec_in_if.sink    i_in,
    jec_out_if.source o_out
);
    import jec_pkg::*;

    logic       r_iv;
    logic       r_op;
    logic [7:0] r_byte;
    t_cfg       r_cfg;
    logic       cfg_wr;
    logic       pref_wr;
    logic       free;
    logic       advance;
    logic       load;
    t_burst     burst;

    assign advance    = r_iv & free;
    assign load       = advance & (burst.cnt != 3'd0);
    assign i_in.ready = !r_iv | free;
    assign i_cfg.ready = 1'b1;
    assign cfg_wr     = i_cfg.valid & i_cfg.ready;
    assign pref_wr    = cfg_wr & (i_cfg.idx == CFG_PREFER_EUC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (i_in.ready) begin
            r_iv <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_op   <= i_in.op;
            r_byte <= i_in.in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.output_code     <= OC_SJIS;
            r_cfg.kanji_in_final  <= 8'h42;
            r_cfg.kanji_out_final <= 8'h4A;
        end else if (cfg_wr) begin
            unique case (t_cfg_idx'(i_cfg.idx))
                CFG_OUTPUT_CODE:     r_cfg.output_code     <= i_cfg.data[1:0];
                CFG_KANJI_IN_FINAL:  r_cfg.kanji_in_final  <= i_cfg.data;
                CFG_KANJI_OUT_FINAL: r_cfg.kanji_out_final <= i_cfg.data;
                CFG_PREFER_EUC: begin
                    // loads the running preference inside the decoder
                end
            endcase
        end
    end

    jec_xlate u_xlate (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (advance),
        .i_op       (r_op),
        .i_byte     (r_byte),
        .i_cfg      (r_cfg),
        .i_pref_wr  (pref_wr),
        .i_pref_val (i_cfg.data[0]),
        .o_burst    (burst)
    );

    jec_burst u_burst (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_burst (burst),
        .o_free  (free),
        .o_out   (o_out)
    );

    `JEC_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_iv && !free, r_iv && $stable(r_byte) && $stable(r_op), "stalled input lost")

endmodule

// ===== hdl/jec_xlate.sv =====
// decode state registers and single-pass translation of one byte into an output burst
module jec_xlate (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_go,
    input  logic           i_op,
    input  logic [7:0]     i_byte,
    input  jec_pkg::t_cfg  i_cfg,
    input  logic           i_pref_wr,
    input  logic           i_pref_val,
    output jec_pkg::t_burst o_burst
);
    import jec_pkg::*;

    t_state     r_state;
    t_state     n_state;
    t_class     cls;
    t_pend      pk;
    logic       pre_out;
    logic       pre_in;
    logic       post_in;
    logic [1:0] nb;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       pair_go;
    logic [7:0] pair_hi;
    logic [7:0] pair_lo;
    logic [7:0] sj_base;
    logic [7:0] sj_hi;
    logic [7:0] sj_lo;
    logic [7:0] lo_dec;
    logic [8:0] lo_sum;
    logic [8:0] hi_diff;
    logic [7:0] hi_s;
    logic [2:0] v_n;
    t_burst     v_b;

    // shift-jis pair back to jis row and cell
    always_comb begin
        sj_base = r_state.held - ((r_state.held <= 8'h9F) ? 8'h71 : 8'hB1);
        lo_dec  = (i_byte > 8'h7F) ? (i_byte - 8'd1) : i_byte;
        if (lo_dec >= 8'h9E) begin
            sj_lo = lo_dec - 8'h7D;
            sj_hi = {sj_base[6:0], 1'b1} + 8'd1;
        end else begin
            sj_lo = lo_dec - 8'h1F;
            sj_hi = {sj_base[6:0], 1'b1};
        end
    end

    // main decode
    always_comb begin
        cls     = byte_class(i_byte);
        n_state = r_state;
        pk      = r_state.pend;
        pre_out = 1'b0;
        pre_in  = 1'b0;
        post_in = 1'b0;
        nb      = 2'd0;
        b0      = i_byte;
        b1      = i_byte;
        pair_go = 1'b0;
        pair_hi = r_state.held;
        pair_lo = i_byte;
        if (i_op) begin
            pre_out      = (r_state.km != 2'd0);
            n_state.pend = PK_NONE;
            n_state.held = 8'd0;
            n_state.km   = 2'd0;
        end else if (i_byte == ESC_BYTE) begin
            n_state.pend = PK_ESC;
        end else if (pk == PK_ESC) begin
            if (i_byte == DOLLAR_BYTE) begin
                n_state.pend = PK_DOL;
            end else if (i_byte == PAREN_BYTE) begin
                n_state.pend = PK_PAR;
            end else begin
                n_state.pend = PK_NONE;
                nb = 2'd2;
                b0 = ESC_BYTE;
            end
        end else if (pk == PK_DOL && cls.jin) begin
            n_state.km   = 2'd3;
            n_state.pend = PK_NONE;
            pre_in       = 1'b1;
        end else if (pk == PK_PAR && cls.jout) begin
            n_state.km   = 2'd0;
            n_state.pend = PK_NONE;
            pre_out      = 1'b1;
        end else if (pk == PK_SJ && cls.sj2) begin
            n_state.pend  = PK_NONE;
            pre_in        = !r_state.km[1];
            n_state.km[1] = 1'b1;
            pair_go       = 1'b1;
            pair_hi       = sj_hi;
            pair_lo       = sj_lo;
            n_state.pref  = 1'b0;
        end else if (pk == PK_EU && cls.eu2) begin
            n_state.pend  = PK_NONE;
            pre_in        = !r_state.km[1];
            n_state.km[1] = 1'b1;
            pair_go       = 1'b1;
            pair_hi       = {1'b0, r_state.held[6:0]};
            pair_lo       = {1'b0, i_byte[6:0]};
            n_state.pref  = 1'b1;
        end else begin
            // an unmatched lead is dropped
            if (pk == PK_SJ || pk == PK_EU) begin
                pk = PK_NONE;
            end
            n_state.pend = pk;
            if (cls.jis) begin
                if (r_state.km[0]) begin
                    if (pk == PK_JIS) begin
                        pair_go      = 1'b1;
                        n_state.pend = PK_NONE;
                    end else begin
                        n_state.held = i_byte;
                        n_state.pend = PK_JIS;
                    end
                end else begin
                    pre_out       = r_state.km[1];
                    n_state.km[1] = 1'b0;
                    nb            = 2'd1;
                end
            end else if (cls.eu1 && (r_state.pref || !cls.sj1)) begin
                n_state.pend = PK_EU;
                n_state.held = i_byte;
            end else if (cls.sj1) begin
                n_state.pend = PK_SJ;
                n_state.held = i_byte;
            end else if (i_byte == LF_BYTE && i_cfg.output_code == OC_JIS
                         && r_state.km[1]) begin
                pre_out = 1'b1;
                nb      = 2'd1;
                post_in = 1'b1;
            end else begin
                pre_out    = (r_state.km != 2'd0);
                n_state.km = 2'd0;
                nb         = 2'd1;
            end
        end

        // pair in the selected encoding
        lo_sum  = {1'b0, pair_lo} + (pair_hi[0] ? 9'h01F : 9'h07D);
        if (lo_sum >= 9'h07F) begin
            lo_sum = lo_sum + 9'd1;
        end
        hi_diff = {1'b0, pair_hi} - 9'h021;
        hi_s    = hi_diff[8:1] + 8'h81;
        if (pair_go) begin
            unique case (i_cfg.output_code)
                OC_EUC: begin
                    nb = 2'd2;
                    b0 = pair_hi | 8'h80;
                    b1 = pair_lo | 8'h80;
                end
                OC_SJIS: begin
                    nb = 2'd2;
                    b0 = hi_s + ((hi_diff[8] || hi_s > 8'h9F) ? 8'h40 : 8'h00);
                    b1 = lo_sum[7:0];
                end
                OC_JIS: begin
                    nb = 2'd2;
                    b0 = pair_hi;
                    b1 = pair_lo;
                end
                default: begin
                    nb = 2'd0;
                end
            endcase
        end

        // escapes only in jis output
        if (i_cfg.output_code != OC_JIS) begin
            pre_out = 1'b0;
            pre_in  = 1'b0;
            post_in = 1'b0;
        end

        v_n = 3'd0;
        v_b = '0;
        if (pre_out) begin
            v_b.data[0] = ESC_BYTE;
            v_b.data[1] = PAREN_BYTE;
            v_b.data[2] = i_cfg.kanji_out_final;
            v_n         = 3'd3;
        end else if (pre_in) begin
            v_b.data[0] = ESC_BYTE;
            v_b.data[1] = DOLLAR_BYTE;
            v_b.data[2] = i_cfg.kanji_in_final;
            v_n         = 3'd3;
        end
        if (nb != 2'd0) begin
            v_b.data[v_n] = b0;
            v_n           = v_n + 3'd1;
        end
        if (nb == 2'd2) begin
            v_b.data[v_n] = b1;
            v_n           = v_n + 3'd1;
        end
        if (post_in) begin
            v_b.data[v_n]        = ESC_BYTE;
            v_b.data[v_n + 3'd1] = DOLLAR_BYTE;
            v_b.data[v_n + 3'd2] = i_cfg.kanji_in_final;
            v_n                  = v_n + 3'd3;
        end
        v_b.cnt = v_n;
        o_burst = v_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.pend <= PK_NONE;
            r_state.held <= 8'd0;
            r_state.km   <= 2'd0;
            r_state.pref <= 1'b1;
        end else begin
            if (i_go) begin
                r_state.pend <= n_state.pend;
                r_state.held <= n_state.held;
                r_state.km   <= n_state.km;
            end
            if (i_pref_wr) begin
                r_state.pref <= i_pref_val;
            end else if (i_go) begin
                r_state.pref <= n_state.pref;
            end
        end
    end

endmodule

// ===== hdl/jec_burst.sv =====
// output register that hands out a burst of result bytes one transaction at a time
`include "japanese_encoding_converter_top_defines.svh"

module jec_burst (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  jec_pkg::t_burst i_burst,
    output logic            o_free,
    jec_out_if.source       o_out
);
    import jec_pkg::*;

    logic       r_valid;
    logic [2:0] r_idx;
    t_burst     r_burst;
    logic       at_end;
    logic       take;
    logic       fin;

    assign at_end = (r_idx == (r_burst.cnt - 3'd1));
    assign take   = r_valid & o_out.ready;
    assign fin    = take & at_end;
    assign o_free = !r_valid | fin;

    assign o_out.valid    = r_valid;
    assign o_out.out_byte = r_burst.data[r_idx];
    assign o_out.last     = at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= 3'd0;
        end else if (fin) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_burst <= i_burst;
        end
    end

    `JEC_ASSERT(a_idx_in_range, i_clk, i_rst_n, r_valid |-> (r_idx < r_burst.cnt), "index past burst")
    `JEC_ASSERT(a_load_when_free, i_clk, i_rst_n, i_load |-> o_free, "burst overwritten")
    `JEC_ASSERT_NEXT(a_drain, i_clk, i_rst_n, fin && !i_load, !r_valid, "burst not retired")

endmodule

// ===== verif/japanese_encoding_converter_top_test.sv =====
// self-checking testbench for the japanese encoding converter: directed and random byte streams
module japanese_encoding_converter_top_test;
    import jec_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 10;
    localparam int DRAIN_CYCLES   = 16;
    localparam int HOLD_CYCLES    = 400;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int MAX_BURST      = 7;
    localparam int PHASE_ITEMS    = 70;

    localparam logic       OP_DATA = 1'b0;
    localparam logic       OP_EOS  = 1'b1;
    localparam logic [1:0] OC_NONE = 2'd3;

    localparam logic [7:0] CL_JIN  = 8'h01;
    localparam logic [7:0] CL_JOUT = 8'h02;
    localparam logic [7:0] CL_JIS  = 8'h08;
    localparam logic [7:0] CL_SJ1  = 8'h10;
    localparam logic [7:0] CL_SJ2  = 8'h20;
    localparam logic [7:0] CL_EU1  = 8'h40;
    localparam logic [7:0] CL_EU2  = 8'h80;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } t_text_item;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_conv_byte;

    logic i_clk = 1'b0;
    logic i_rst_n;

    jec_in_if  in_ch();
    jec_out_if out_ch();
    jec_cfg_if cfg_ch();

    japanese_encoding_converter_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    t_text_item text_items[$];
    t_conv_byte expected_bytes[$];
    logic [7:0] conv_burst[$];

    // predicted converter state and registers
    t_pend      conv_pend;
    logic [7:0] conv_held;
    logic [1:0] conv_kmode;
    logic       conv_pref;
    logic [1:0] conv_ocode;
    logic [7:0] conv_kin;
    logic [7:0] conv_kout;

    logic in_taken;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_cnt;
    logic hold_req;
    logic hold_done;
    int   in_count;
    int   eos_count;
    int   out_count;
    int   cfg_count;
    int   mismatch_count;

    function automatic logic [7:0] classify(input logic [7:0] c);
        if (c >= 8'h21 && c <= 8'h3F) return CL_JIS;
        if (c == 8'h40) return CL_SJ2 | CL_JIS | CL_JIN;
        if (c == 8'h42) return CL_SJ2 | CL_JIS | CL_JOUT | CL_JIN;
        if (c == 8'h48 || c == 8'h4A) return CL_SJ2 | CL_JIS | CL_JOUT;
        if (c >= 8'h41 && c <= 8'h7E) return CL_SJ2 | CL_JIS;
        if (c == 8'h80 || c == 8'hA0) return CL_SJ2;
        if (c >= 8'h81 && c <= 8'h9F) return CL_SJ2 | CL_SJ1;
        if (c >= 8'hA1 && c <= 8'hDF) return CL_EU2 | CL_EU1 | CL_SJ2;
        if (c >= 8'hE0 && c <= 8'hFC) return CL_EU2 | CL_EU1 | CL_SJ2 | CL_SJ1;
        if (c == 8'hFD || c == 8'hFE) return CL_EU2 | CL_EU1;
        return 8'h00;
    endfunction

    function automatic void burst_byte(input logic [7:0] b);
        if (conv_burst.size() < MAX_BURST) conv_burst.push_back(b);
    endfunction

    function automatic void kanji_in_escape();
        if (conv_ocode == OC_JIS) begin
            burst_byte(ESC_BYTE);
            burst_byte(DOLLAR_BYTE);
            burst_byte(conv_kin);
        end
    endfunction

    function automatic void kanji_out_escape();
        if (conv_ocode == OC_JIS) begin
            burst_byte(ESC_BYTE);
            burst_byte(PAREN_BYTE);
            burst_byte(conv_kout);
        end
    endfunction

    function automatic void open_kanji();
        if (!conv_kmode[1]) begin
            kanji_in_escape();
            conv_kmode[1] = 1'b1;
        end
    endfunction

    // emit one jis code point in the selected output encoding
    function automatic void kanji_pair(input int unsigned hi, input int unsigned lo);
        case (conv_ocode)
            OC_EUC: begin
                burst_byte(8'(hi | 32'h80));
                burst_byte(8'(lo | 32'h80));
            end
            OC_SJIS: begin
                lo = lo + (hi[0] ? 32'h1F : 32'h7D);
                if (lo >= 32'h7F) lo = lo + 1;
                hi = ((hi - 32'h21) >> 1) + 32'h81;
                if (hi > 32'h9F) hi = hi + 32'h40;
                burst_byte(8'(hi));
                burst_byte(8'(lo));
            end
            OC_JIS: begin
                burst_byte(8'(hi));
                burst_byte(8'(lo));
            end
            default: ;
        endcase
    endfunction

    function automatic void convert_text_byte(input logic [7:0] c);
        logic [7:0]  cls;
        int unsigned hi;
        int unsigned lo;
        cls = classify(c);
        if (c == ESC_BYTE) begin
            conv_pend = PK_ESC;
            return;
        end
        if (conv_pend == PK_ESC) begin
            if (c == DOLLAR_BYTE) begin
                conv_pend = PK_DOL;
            end else if (c == PAREN_BYTE) begin
                conv_pend = PK_PAR;
            end else begin
                conv_pend = PK_NONE;
                burst_byte(ESC_BYTE);
                burst_byte(c);
            end
            return;
        end
        if (conv_pend == PK_DOL) begin
            if ((cls & CL_JIN) != 0) begin
                conv_kmode = 2'b11;
                kanji_in_escape();
                conv_pend = PK_NONE;
                return;
            end
        end else if (conv_pend == PK_PAR) begin
            if ((cls & CL_JOUT) != 0) begin
                conv_kmode = 2'b00;
                kanji_out_escape();
                conv_pend = PK_NONE;
                return;
            end
        end
        if (conv_pend == PK_SJ) begin
            conv_pend = PK_NONE;
            if ((cls & CL_SJ2) != 0) begin
                hi = conv_held;
                lo = c;
                hi = hi - ((hi <= 32'h9F) ? 32'h71 : 32'hB1);
                hi = (hi * 2 + 1) & 32'hFF;
                if (lo > 32'h7F) lo = lo - 1;
                if (lo >= 32'h9E) begin
                    lo = lo - 32'h7D;
                    hi = hi + 1;
                end else begin
                    lo = lo - 32'h1F;
                end
                open_kanji();
                kanji_pair(hi & 32'hFF, lo & 32'hFF);
                conv_pref = 1'b0;
                return;
            end
        end
        if (conv_pend == PK_EU) begin
            conv_pend = PK_NONE;
            if ((cls & CL_EU2) != 0) begin
                open_kanji();
                kanji_pair({25'd0, conv_held[6:0]}, {25'd0, c[6:0]});
                conv_pref = 1'b1;
                return;
            end
        end
        if ((cls & CL_JIS) != 0) begin
            if (conv_kmode[0]) begin
                if (conv_pend == PK_JIS) begin
                    kanji_pair(conv_held, c);
                    conv_pend = PK_NONE;
                end else begin
                    conv_held = c;
                    conv_pend = PK_JIS;
                end
            end else begin
                if (conv_kmode[1]) begin
                    kanji_out_escape();
                    conv_kmode[1] = 1'b0;
                end
                burst_byte(c);
            end
            return;
        end
        if ((cls & CL_EU1) != 0 && (conv_pref || (cls & CL_SJ1) == 0)) begin
            conv_pend = PK_EU;
            conv_held = c;
            return;
        end
        if ((cls & CL_SJ1) != 0) begin
            conv_pend = PK_SJ;
            conv_held = c;
            return;
        end
        if (c == LF_BYTE && conv_ocode == OC_JIS && conv_kmode[1]) begin
            kanji_out_escape();
            burst_byte(LF_BYTE);
            kanji_in_escape();
        end else begin
            if (conv_kmode != 2'b00) begin
                kanji_out_escape();
                conv_kmode = 2'b00;
            end
            burst_byte(c);
        end
    endfunction

    function automatic void predict_conversion(input logic op, input logic [7:0] c);
        conv_burst.delete();
        if (op == OP_EOS) begin
            if (conv_kmode != 2'b00) kanji_out_escape();
            conv_pend  = PK_NONE;
            conv_held  = 8'h00;
            conv_kmode = 2'b00;
        end else begin
            convert_text_byte(c);
        end
        foreach (conv_burst[i]) begin
            expected_bytes.push_back('{data: conv_burst[i], last: (i == conv_burst.size() - 1)});
        end
    endfunction

    function automatic void apply_reg_write(input logic [1:0] idx, input logic [7:0] value);
        case (idx)
            CFG_OUTPUT_CODE:     conv_ocode = value[1:0];
            CFG_KANJI_IN_FINAL:  conv_kin = value;
            CFG_KANJI_OUT_FINAL: conv_kout = value;
            CFG_PREFER_EUC:      conv_pref = value[0];
            default: ;
        endcase
    endfunction

    function automatic void flag_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch at output byte %0d: %s expected %h got %h",
                     out_count, what, want, got);
        end
    endfunction

    function automatic void check_output(input logic [7:0] got_byte, input logic got_last);
        t_conv_byte want;
        if (expected_bytes.size() == 0) begin
            flag_mismatch("nothing expected, out_byte", 0, got_byte);
            return;
        end
        want = expected_bytes.pop_front();
        if (got_byte !== want.data) flag_mismatch("out_byte", want.data, got_byte);
        if (got_last !== want.last) flag_mismatch("last", want.last, got_last);
    endfunction

    // transaction monitor and predictor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken   <= 1'b0;
            conv_pend  = PK_NONE;
            conv_held  = 8'h00;
            conv_kmode = 2'b00;
            conv_pref  = 1'b1;
            conv_ocode = OC_SJIS;
            conv_kin   = 8'h42;
            conv_kout  = 8'h4A;
        end else begin
            in_taken <= in_ch.valid && in_ch.ready;
            if (out_ch.valid && out_ch.ready) begin
                check_output(out_ch.out_byte, out_ch.last);
                out_count++;
            end
            if (in_ch.valid && in_ch.ready) begin
                predict_conversion(in_ch.op, in_ch.in_byte);
                in_count++;
                if (in_ch.op == OP_EOS) eos_count++;
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                apply_reg_write(cfg_ch.idx, cfg_ch.data);
                cfg_count++;
            end
        end
    end

    // input driver
    always @(negedge i_clk) begin : drive_text
        t_text_item next_item;
        if (!i_rst_n) begin
            in_ch.valid   <= 1'b0;
            in_ch.op      <= OP_DATA;
            in_ch.in_byte <= 8'h00;
        end else if (!in_ch.valid || in_taken) begin
            if (text_items.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                next_item = text_items.pop_front();
                in_ch.valid   <= 1'b1;
                in_ch.op      <= next_item.op;
                in_ch.in_byte <= next_item.data;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (hold_req && !hold_done) begin
            hold_cnt  <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= (hold_cnt == 0) && ($urandom_range(99, 0) >= recv_idle_pct);
    end

    task automatic add_item(input logic op, input logic [7:0] b);
        text_items.push_back('{op: op, data: b});
    endtask

    task automatic add_byte(input logic [7:0] b);
        add_item(OP_DATA, b);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.idx   <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (text_items.size() != 0 || in_ch.valid || expected_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic start_phase(input logic [1:0] code, input logic [7:0] kin,
                               input logic [7:0] kout, input logic pref, input int idle_mode);
        wait_drained();
        case (idle_mode)
            0: begin send_idle_pct = 9;  recv_idle_pct = 64; end
            1: begin send_idle_pct = 64; recv_idle_pct = 9;  end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
        endcase
        write_reg(CFG_OUTPUT_CODE, {6'd0, code});
        write_reg(CFG_KANJI_IN_FINAL, kin);
        write_reg(CFG_KANJI_OUT_FINAL, kout);
        write_reg(CFG_PREFER_EUC, {7'd0, pref});
        @(posedge i_clk);
    endtask

    task automatic queue_random_text(input int count);
        int target;
        int pick;
        int pairs;
        target = text_items.size() + count;
        while (text_items.size() < target) begin
            pick = $urandom_range(99, 0);
            if (pick < 15) begin
                // jis run with designations
                add_byte(ESC_BYTE);
                add_byte(DOLLAR_BYTE);
                add_byte($urandom_range(1, 0) ? 8'h42 : 8'h40);
                pairs = $urandom_range(4, 1);
                for (int i = 0; i < pairs; i++) begin
                    add_byte(8'($urandom_range(8'h7E, 8'h21)));
                    add_byte(8'($urandom_range(8'h7E, 8'h21)));
                    if ($urandom_range(5, 0) == 0) add_byte(LF_BYTE);
                end
                if ($urandom_range(4, 0) != 0) begin
                    add_byte(ESC_BYTE);
                    add_byte(PAREN_BYTE);
                    case ($urandom_range(2, 0))
                        0: add_byte(8'h42);
                        1: add_byte(8'h48);
                        default: add_byte(8'h4A);
                    endcase
                end
            end else if (pick < 35) begin
                add_byte($urandom_range(1, 0) ? 8'($urandom_range(8'h9F, 8'h81))
                                              : 8'($urandom_range(8'hFC, 8'hE0)));
                add_byte($urandom_range(1, 0) ? 8'($urandom_range(8'h7E, 8'h40))
                                              : 8'($urandom_range(8'hFC, 8'h80)));
            end else if (pick < 55) begin
                add_byte(8'($urandom_range(8'hFE, 8'hA1)));
                add_byte(8'($urandom_range(8'hFE, 8'hA1)));
            end else if (pick < 72) begin
                if ($urandom_range(5, 0) == 0) add_byte(LF_BYTE);
                else add_byte(8'($urandom_range(8'h7E, 8'h20)));
            end else if (pick < 80) begin
                add_item(OP_EOS, 8'($urandom_range(255, 0)));
            end else begin
                // noise and broken escapes
                case ($urandom_range(3, 0))
                    0: add_byte(8'($urandom_range(255, 0)));
                    1: begin
                        add_byte(ESC_BYTE);
                        add_byte(8'($urandom_range(255, 0)));
                    end
                    2: begin
                        add_byte(ESC_BYTE);
                        add_byte(ESC_BYTE);
                    end
                    default: begin
                        add_byte(ESC_BYTE);
                        add_byte($urandom_range(1, 0) ? DOLLAR_BYTE : PAREN_BYTE);
                        add_byte(8'($urandom_range(255, 0)));
                    end
                endcase
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.op       = OP_DATA;
        in_ch.in_byte  = 8'h00;
        out_ch.ready   = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.idx     = CFG_OUTPUT_CODE;
        cfg_ch.data    = 8'h00;
        hold_req       = 1'b0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        in_count       = 0;
        eos_count      = 0;
        out_count      = 0;
        cfg_count      = 0;
        mismatch_count = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed stream in jis output
        start_phase(OC_JIS, 8'h40, 8'h48, 1'b1, 0);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(ESC_BYTE);
        add_byte(DOLLAR_BYTE);
        add_byte(8'h42);
        add_byte(8'h21);
        add_byte(8'h7E);
        add_byte(LF_BYTE);
        add_byte(ESC_BYTE);
        add_byte(PAREN_BYTE);
        add_byte(8'h4A);
        add_byte(ESC_BYTE);
        add_byte(ESC_BYTE);
        add_byte(8'h41);
        add_byte(8'h81);
        add_byte(8'h40);
        add_byte(8'hFC);
        add_byte(8'hFC);
        add_byte(8'hFE);
        add_byte(8'hA1);
        add_byte(8'h81);
        add_byte(LF_BYTE);
        add_byte(ESC_BYTE);
        add_byte(DOLLAR_BYTE);
        add_byte(8'h5A);
        add_item(OP_EOS, 8'hFF);

        start_phase(OC_SJIS, 8'h00, 8'hFF, 1'b0, 0);
        queue_random_text(PHASE_ITEMS);
        start_phase(OC_EUC, 8'h42, 8'h4A, 1'b1, 0);
        queue_random_text(PHASE_ITEMS);
        start_phase(OC_JIS, 8'hFF, 8'h00, 1'b0, 1);
        queue_random_text(PHASE_ITEMS);
        start_phase(OC_NONE, 8'h40, 8'h42, 1'b1, 1);
        queue_random_text(PHASE_ITEMS);
        start_phase(OC_JIS, 8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                    1'($urandom_range(1, 0)), 2);
        hold_req <= 1'b1;
        queue_random_text(PHASE_ITEMS);
        start_phase(OC_SJIS, 8'h42, 8'h4A, 1'($urandom_range(1, 0)), 2);
        queue_random_text(PHASE_ITEMS);

        wait_drained();
        $display("run covered %0d input transactions (%0d end of stream), %0d register writes",
                 in_count, eos_count, cfg_count);
        $display("%0d output bytes checked over jis, sjis, euc and unused output codes, %0d mismatches",
                 out_count, mismatch_count);
        if (mismatch_count == 0 && expected_bytes.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("timeout with %0d output bytes still expected", expected_bytes.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/jec_pkg.sv
hdl/jec_ifs.sv
hdl/jec_xlate.sv
hdl/jec_burst.sv
hdl/japanese_encoding_converter_top.sv
verif/japanese_encoding_converter_top_test.sv
